@@ hdl/edt_pkg.sv @@
`default_nettype none

package edt_pkg;

    // Vertex numbers and the packed canonical key (smaller vertex in the low half).
    localparam int VERTEX_BITS = 16;
    localparam int KEY_BITS    = 2 * VERTEX_BITS;

    // Edge table and bucket table sizes. BUCKET_COUNT must be a power of two,
    // because the hash is reduced to a bucket number by keeping its low bits.
    localparam int TABLE_DEPTH  = 4096;
    localparam int BUCKET_COUNT = 8192;

    localparam int IDX_BITS   = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS   = $clog2(TABLE_DEPTH + 1);
    localparam int BKT_BITS   = $clog2(BUCKET_COUNT);
    localparam int PROBE_BITS = BKT_BITS + 1;

    // Width of the reported signed edge index.
    localparam int EDGE_INDEX_BITS = 13;

    // Multiplicative hash constant.
    localparam logic [KEY_BITS-1:0] HASH_MULT = 32'h9E3779B1;
    localparam int HASH_SHIFT = 15;

    // Input modes.
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef logic [VERTEX_BITS-1:0]            vertex_t;
    typedef logic [KEY_BITS-1:0]               key_t;
    typedef logic [IDX_BITS-1:0]               idx_t;
    typedef logic [CNT_BITS-1:0]               cnt_t;
    typedef logic [BKT_BITS-1:0]               bkt_t;
    typedef logic [PROBE_BITS-1:0]             probe_t;
    typedef logic signed [EDGE_INDEX_BITS-1:0] edge_index_t;

endpackage

`default_nettype wire

@@ hdl/edt_if.sv @@
`default_nettype none

// Input channel: one add or clear transaction.
interface edt_in_if;
    logic                  valid;
    logic                  ready;
    logic                  mode;
    edt_pkg::vertex_t      vertex_a;
    edt_pkg::vertex_t      vertex_b;

    modport source (output valid, output mode, output vertex_a, output vertex_b, input ready);
    modport sink   (input valid, input mode, input vertex_a, input vertex_b, output ready);
endinterface

// Output channel: one result transaction per input transaction.
interface edt_out_if;
    logic                  valid;
    logic                  ready;
    edt_pkg::edge_index_t  edge_index;
    logic                  was_added;
    logic                  table_full;

    modport source (output valid, output edge_index, output was_added, output table_full,
                    input ready);
    modport sink   (input valid, input edge_index, input was_added, input table_full,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/edt_ram.sv @@
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module edt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/edt_hash.sv @@
`default_nettype none

// Bucket hash: registered multiply, then an xor-shift fold and low-bit reduction.
module edt_hash (
    input  wire logic          clk,
    input  wire edt_pkg::key_t key,
    output edt_pkg::bkt_t      pos
);

    edt_pkg::key_t prod_reg;
    edt_pkg::key_t mix;

    // The product is taken modulo 2^32, as the key width sets.
    always_ff @(posedge clk)
    begin
        prod_reg <= key * edt_pkg::HASH_MULT;
    end

    assign mix = prod_reg ^ (prod_reg >> edt_pkg::HASH_SHIFT);
    assign pos = mix[edt_pkg::BKT_BITS-1:0];

endmodule

`default_nettype wire

@@ hdl/edge_dedup_table.sv @@
`default_nettype none

// Deduplicating store of undirected edges.
// edge_in carries one transaction per item: mode 0 looks up the vertex pair
// (vertex_a, vertex_b) and appends it when new, mode 1 clears the table.
// edge_out returns exactly one transaction per item, in order: the edge index
// (negated when vertex_a > vertex_b), was_added and table_full.
// Items are handled one at a time by a sequencer around two memories: the
// bucket memory and the edge pair memory, each with a registered read port.
// A lookup registers the hash product, folds it and reads the home bucket,
// then probes buckets in turn; each probe of a bucket that holds an edge is
// one bucket read followed by one pair read. A matching pair ends a hit;
// a miss ends on an empty bucket. The next item is accepted in the cycle after
// the result is loaded into the output register, even while that result waits.
// A clear item and reset both sweep the bucket memory, one bucket a cycle,
// over all BUCKET_COUNT (8192) buckets, during which edge_in is not ready;
// a clear item reports its result after the sweep.
// When edge_out stalls, the finished result waits in the sequencer until the
// output register frees up; no result is dropped.
module edge_dedup_table (
    input  wire logic  clk,
    input  wire logic  rst_n,
    edt_in_if.sink     edge_in,
    edt_out_if.source  edge_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HASH  = 3'd1;
    localparam logic [2:0] S_MIX   = 3'd2;
    localparam logic [2:0] S_BKT   = 3'd3;
    localparam logic [2:0] S_PAIR  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_CLEAR = 3'd6;

    localparam edt_pkg::bkt_t   BKT_LAST   = edt_pkg::BKT_BITS'(edt_pkg::BUCKET_COUNT - 1);
    localparam edt_pkg::probe_t PROBE_LAST = edt_pkg::PROBE_BITS'(edt_pkg::BUCKET_COUNT - 1);
    localparam edt_pkg::cnt_t   CNT_FULL   = edt_pkg::CNT_BITS'(edt_pkg::TABLE_DEPTH);
    localparam edt_pkg::cnt_t   CNT_RESET  = edt_pkg::CNT_BITS'(1);

    logic [2:0]           state_reg, state_next;
    edt_pkg::key_t        key_reg, key_next;
    logic                 swapped_reg, swapped_next;
    edt_pkg::bkt_t        pos_reg, pos_next;
    edt_pkg::probe_t      probe_reg, probe_next;
    edt_pkg::idx_t        slot_reg, slot_next;
    edt_pkg::cnt_t        count_reg, count_next;
    edt_pkg::bkt_t        sweep_reg, sweep_next;
    logic                 clear_emit_reg, clear_emit_next;
    edt_pkg::idx_t        res_found_reg, res_found_next;
    logic                 res_added_reg, res_added_next;
    logic                 res_full_reg, res_full_next;
    logic                 out_valid_reg, out_valid_next;
    edt_pkg::edge_index_t out_index_reg, out_index_next;
    logic                 out_added_reg, out_added_next;
    logic                 out_full_reg, out_full_next;

    edt_pkg::bkt_t        hash_pos;
    edt_pkg::bkt_t        pos_inc;
    edt_pkg::edge_index_t res_index;
    logic                 in_accept;
    logic                 room;

    logic                 bkt_we;
    edt_pkg::bkt_t        bkt_waddr;
    edt_pkg::idx_t        bkt_wdata;
    edt_pkg::bkt_t        bkt_raddr;
    edt_pkg::idx_t        bkt_rdata;
    logic                 pair_we;
    edt_pkg::key_t        pair_rdata;

    edt_hash u_hash (
        .clk (clk),
        .key (key_reg),
        .pos (hash_pos)
    );

    edt_ram #(
        .WIDTH (edt_pkg::IDX_BITS),
        .DEPTH (edt_pkg::BUCKET_COUNT)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (bkt_raddr),
        .rdata (bkt_rdata)
    );

    edt_ram #(
        .WIDTH (edt_pkg::KEY_BITS),
        .DEPTH (edt_pkg::TABLE_DEPTH)
    ) u_pair_ram (
        .clk   (clk),
        .we    (pair_we),
        .waddr (count_reg[edt_pkg::IDX_BITS-1:0]),
        .wdata (key_reg),
        .raddr (bkt_rdata),
        .rdata (pair_rdata)
    );

    assign edge_in.ready = (state_reg == S_IDLE);
    assign in_accept     = edge_in.valid && edge_in.ready;
    assign room          = (count_reg < CNT_FULL);
    assign pos_inc       = (pos_reg == BKT_LAST) ? '0 : pos_reg + 1'b1;

    // Signed result: the found index, negated when the pair was swapped.
    always_comb
    begin
        res_index = edt_pkg::EDGE_INDEX_BITS'(res_found_reg);
        if (swapped_reg)
        begin
            res_index = -res_index;
        end
    end

    // Writes: the sweep zeroes buckets; an append claims one, stores the pair.
    always_comb
    begin
        bkt_we    = 1'b0;
        bkt_waddr = pos_reg;
        bkt_wdata = count_reg[edt_pkg::IDX_BITS-1:0];
        pair_we   = 1'b0;
        if (state_reg == S_CLEAR)
        begin
            bkt_we    = 1'b1;
            bkt_waddr = sweep_reg;
            bkt_wdata = '0;
        end
        else if (state_reg == S_BKT && bkt_rdata == '0 && room)
        begin
            bkt_we  = 1'b1;
            pair_we = 1'b1;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_MIX:   bkt_raddr = hash_pos;
            S_PAIR:  bkt_raddr = pos_inc;
            default: bkt_raddr = pos_reg;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        swapped_next    = swapped_reg;
        pos_next        = pos_reg;
        probe_next      = probe_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        sweep_next      = sweep_reg;
        clear_emit_next = clear_emit_reg;
        res_found_next  = res_found_reg;
        res_added_next  = res_added_reg;
        res_full_next   = res_full_reg;
        out_valid_next  = out_valid_reg && !edge_out.ready;
        out_index_next  = out_index_reg;
        out_added_next  = out_added_reg;
        out_full_next   = out_full_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (edge_in.mode == edt_pkg::MODE_CLEAR)
                    begin
                        state_next      = S_CLEAR;
                        sweep_next      = '0;
                        clear_emit_next = 1'b1;
                        count_next      = CNT_RESET;
                    end
                    else
                    begin
                        state_next   = S_HASH;
                        swapped_next = edge_in.vertex_a > edge_in.vertex_b;
                        if (edge_in.vertex_a > edge_in.vertex_b)
                        begin
                            key_next = {edge_in.vertex_a, edge_in.vertex_b};
                        end
                        else
                        begin
                            key_next = {edge_in.vertex_b, edge_in.vertex_a};
                        end
                    end
                end
            end

            S_HASH:
            begin
                state_next = S_MIX;
            end

            S_MIX:
            begin
                pos_next   = hash_pos;
                probe_next = '0;
                state_next = S_BKT;
            end

            S_BKT:
            begin
                slot_next = bkt_rdata;
                if (bkt_rdata == '0)
                begin
                    // Empty bucket: append if there is room.
                    state_next     = S_EMIT;
                    res_added_next = room;
                    res_full_next  = !room;
                    if (room)
                    begin
                        res_found_next = count_reg[edt_pkg::IDX_BITS-1:0];
                        count_next     = count_reg + 1'b1;
                    end
                    else
                    begin
                        res_found_next = '0;
                    end
                end
                else
                begin
                    state_next = S_PAIR;
                end
            end

            S_PAIR:
            begin
                if (pair_rdata == key_reg)
                begin
                    state_next     = S_EMIT;
                    res_found_next = slot_reg;
                    res_added_next = 1'b0;
                    res_full_next  = 1'b0;
                end
                else if (probe_reg == PROBE_LAST)
                begin
                    // Every bucket probed without a match or a free bucket.
                    state_next     = S_EMIT;
                    res_found_next = '0;
                    res_added_next = 1'b0;
                    res_full_next  = 1'b1;
                end
                else
                begin
                    pos_next   = pos_inc;
                    probe_next = probe_reg + 1'b1;
                    state_next = S_BKT;
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || edge_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = res_index;
                    out_added_next = res_added_reg;
                    out_full_next  = res_full_reg;
                    state_next     = S_IDLE;
                end
            end

            S_CLEAR:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == BKT_LAST)
                begin
                    if (clear_emit_reg)
                    begin
                        state_next     = S_EMIT;
                        swapped_next   = 1'b0;
                        res_found_next = '0;
                        res_added_next = 1'b0;
                        res_full_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            count_reg      <= CNT_RESET;
            sweep_reg      <= '0;
            clear_emit_reg <= 1'b0;
            probe_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            sweep_reg      <= sweep_next;
            clear_emit_reg <= clear_emit_next;
            probe_reg      <= probe_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        swapped_reg   <= swapped_next;
        pos_reg       <= pos_next;
        slot_reg      <= slot_next;
        res_found_reg <= res_found_next;
        res_added_reg <= res_added_next;
        res_full_reg  <= res_full_next;
        out_index_reg <= out_index_next;
        out_added_reg <= out_added_next;
        out_full_reg  <= out_full_next;
    end

    assign edge_out.valid      = out_valid_reg;
    assign edge_out.edge_index = out_index_reg;
    assign edge_out.was_added  = out_added_reg;
    assign edge_out.table_full = out_full_reg;

`ifndef ASSERT_OFF
    // The entry count stays between the dummy entry and the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_RESET && count_reg <= CNT_FULL)
        else $error("entry count out of range");

    // A result is never both appended and full.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_added_reg && out_full_reg))
        else $error("was_added and table_full both set");

    // A full result reports index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_full_reg) |-> (out_index_reg == '0))
        else $error("full result with nonzero index");

    // An append only happens while the table has room, and bumps the count.
    assert property (@(posedge clk) disable iff (!rst_n)
        pair_we |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append without count increment");

    // No item is taken while the bucket sweep runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !edge_in.ready)
        else $error("input ready during clear sweep");
`endif

endmodule

`default_nettype wire

@@ dv/tb_edge_dedup_table.sv @@
`default_nettype none

module tb_edge_dedup_table;

    // One result transaction as seen on edge_out.
    typedef struct packed {
        edt_pkg::edge_index_t edge_index;
        logic                 was_added;
        logic                 table_full;
    } edge_result_t;

    // One row of the directed table. Rows with pinned set carry a result typed in by hand.
    typedef struct packed {
        logic             mode;
        edt_pkg::vertex_t vertex_a;
        edt_pkg::vertex_t vertex_b;
        logic             pinned;
        edge_result_t     result;
    } edge_row_t;

    localparam int CYCLE_LIMIT      = 3_000_000;
    localparam int RANDOM_PER_PHASE = 577;
    localparam int MAX_REPORTS      = 30;
    localparam int DIRECTED_COUNT   = 20;

    localparam edge_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{edt_pkg::MODE_ADD,   16'h0000, 16'h0000, 1'b1, '{13'sd1, 1'b1, 1'b0}},
        '{edt_pkg::MODE_ADD,   16'h0000, 16'h0000, 1'b1, '{13'sd1, 1'b0, 1'b0}},
        '{edt_pkg::MODE_ADD,   16'hFFFF, 16'hFFFF, 1'b1, '{13'sd2, 1'b1, 1'b0}},
        '{edt_pkg::MODE_ADD,   16'hFFFF, 16'h0000, 1'b1, '{-13'sd3, 1'b1, 1'b0}},
        '{edt_pkg::MODE_ADD,   16'h0000, 16'hFFFF, 1'b1, '{13'sd3, 1'b0, 1'b0}},
        '{edt_pkg::MODE_ADD,   16'h1234, 16'h1234, 1'b1, '{13'sd4, 1'b1, 1'b0}},
        '{edt_pkg::MODE_ADD,   16'h0001, 16'h0002, 1'b0, '0},
        '{edt_pkg::MODE_ADD,   16'h0002, 16'h0001, 1'b0, '0},
        '{edt_pkg::MODE_ADD,   16'h8000, 16'h7FFF, 1'b0, '0},
        '{edt_pkg::MODE_ADD,   16'h7FFF, 16'h8000, 1'b0, '0},
        '{edt_pkg::MODE_ADD,   16'hAAAA, 16'h5555, 1'b0, '0},
        '{edt_pkg::MODE_ADD,   16'h5555, 16'hAAAA, 1'b0, '0},
        '{edt_pkg::MODE_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, '{13'sd0, 1'b0, 1'b0}},
        '{edt_pkg::MODE_ADD,   16'h0002, 16'h0001, 1'b1, '{-13'sd1, 1'b1, 1'b0}},
        '{edt_pkg::MODE_ADD,   16'h0001, 16'h0002, 1'b1, '{13'sd1, 1'b0, 1'b0}},
        '{edt_pkg::MODE_ADD,   16'hFFFF, 16'hFFFF, 1'b1, '{13'sd2, 1'b1, 1'b0}},
        '{edt_pkg::MODE_ADD,   16'h0000, 16'h0000, 1'b1, '{13'sd3, 1'b1, 1'b0}},
        '{edt_pkg::MODE_CLEAR, 16'h0000, 16'h0000, 1'b1, '{13'sd0, 1'b0, 1'b0}},
        '{edt_pkg::MODE_ADD,   16'hFFFE, 16'h0001, 1'b1, '{-13'sd1, 1'b1, 1'b0}},
        '{edt_pkg::MODE_ADD,   16'h0001, 16'hFFFE, 1'b1, '{13'sd1, 1'b0, 1'b0}}
    };

    logic clk;
    logic rst_n;

    edt_in_if  edge_in_bus ();
    edt_out_if edge_out_bus ();

    edge_dedup_table DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .edge_in  (edge_in_bus),
        .edge_out (edge_out_bus)
    );

    // Shadow copy of the bucket table, the stored pairs and the entry count.
    edt_pkg::idx_t bucket_slot [edt_pkg::BUCKET_COUNT];
    edt_pkg::key_t edge_key [edt_pkg::TABLE_DEPTH];
    edt_pkg::cnt_t entry_total;

    edge_result_t pending_results [$];
    logic [31:0]  recent_pairs [$];

    // Hand-typed result that travels with the transaction on the bus.
    logic         pin_on;
    edge_result_t pin_result;

    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;
    int error_count;
    int accepted_items;
    int clear_count;
    int added_count;
    int hit_count;
    int full_count;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Empty every bucket and restart numbering after the dummy entry.
    function automatic void clear_tables();
        for (int i = 0; i < edt_pkg::BUCKET_COUNT; i++)
            bucket_slot[i] = '0;
        for (int i = 0; i < edt_pkg::TABLE_DEPTH; i++)
            edge_key[i] = '0;
        entry_total = edt_pkg::cnt_t'(1);
    endfunction

    // Clear, or look up the canonical pair by linear probing and append it on a miss.
    function automatic edge_result_t lookup_edge(logic mode, edt_pkg::vertex_t va,
                                                 edt_pkg::vertex_t vb);
        edge_result_t     r;
        logic             swapped;
        logic             have_slot;
        edt_pkg::vertex_t lo;
        edt_pkg::vertex_t hi;
        edt_pkg::key_t    key;
        logic [31:0]      h;
        edt_pkg::bkt_t    pos;
        edt_pkg::idx_t    found;
        int               signed_idx;
        r = '0;
        if (mode == edt_pkg::MODE_CLEAR)
        begin
            clear_tables();
            return r;
        end
        swapped = va > vb;
        lo = swapped ? vb : va;
        hi = swapped ? va : vb;
        key = {hi, lo};
        h = key * edt_pkg::HASH_MULT;
        h = h ^ (h >> edt_pkg::HASH_SHIFT);
        pos = h[edt_pkg::BKT_BITS-1:0];
        found = '0;
        have_slot = 1'b0;
        for (int probes = 0; probes < edt_pkg::BUCKET_COUNT; probes++)
        begin
            if (bucket_slot[pos] == '0)
            begin
                have_slot = 1'b1;
                break;
            end
            if (edge_key[bucket_slot[pos]] == key)
            begin
                found = bucket_slot[pos];
                break;
            end
            pos = pos + 1'b1;
        end
        if (found == '0)
        begin
            if (!have_slot || entry_total >= edt_pkg::TABLE_DEPTH)
            begin
                r.table_full = 1'b1;
            end
            else
            begin
                found = edt_pkg::idx_t'(entry_total);
                edge_key[found] = key;
                bucket_slot[pos] = found;
                entry_total = entry_total + 1'b1;
                r.was_added = 1'b1;
            end
        end
        signed_idx = int'(found);
        if (swapped)
            signed_idx = -signed_idx;
        r.edge_index = edt_pkg::edge_index_t'(signed_idx);
        return r;
    endfunction

    // Predict the result of every accepted input transaction.
    always @(posedge clk)
    begin : accept_monitor
        edge_result_t r;
        if (rst_n && edge_in_bus.valid && edge_in_bus.ready)
        begin
            r = lookup_edge(edge_in_bus.mode, edge_in_bus.vertex_a, edge_in_bus.vertex_b);
            if (pin_on)
                r = pin_result;
            pending_results = {pending_results, r};
            accepted_items++;
        end
    end

    // Compare each result transaction with the oldest expectation.
    // Reports list index, added and full in that order.
    always @(posedge clk)
    begin : result_checker
        edge_result_t want;
        if (rst_n && edge_out_bus.valid && edge_out_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result %0d %0b %0b, expected none",
                             $time, edge_out_bus.edge_index, edge_out_bus.was_added,
                             edge_out_bus.table_full);
            end
            else
            begin
                want = pending_results.pop_front();
                if (edge_out_bus.edge_index !== want.edge_index
                    || edge_out_bus.was_added !== want.was_added
                    || edge_out_bus.table_full !== want.table_full)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: mismatch: expected %0d %0b %0b, got %0d %0b %0b",
                                 $time, want.edge_index, want.was_added, want.table_full,
                                 edge_out_bus.edge_index, edge_out_bus.was_added,
                                 edge_out_bus.table_full);
                end
                if (want.table_full)
                    full_count++;
                else if (want.was_added)
                    added_count++;
                else if (want.edge_index != '0)
                    hit_count++;
            end
        end
    end

    // Receiver stalls at the rate of the current phase.
    always @(negedge clk)
        edge_out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timed out after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("edge_dedup_table regression: fail");
            $finish;
        end
    end

    // Present one transaction, idling first at the sender rate, and wait for acceptance.
    task automatic send_edge(input logic mode, input edt_pkg::vertex_t va,
                             input edt_pkg::vertex_t vb,
                             input logic pinned, input edge_result_t pin);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            edge_in_bus.valid = 1'b0;
            @(negedge clk);
        end
        edge_in_bus.mode     = mode;
        edge_in_bus.vertex_a = va;
        edge_in_bus.vertex_b = vb;
        pin_on               = pinned;
        pin_result           = pin;
        edge_in_bus.valid    = 1'b1;
        do
            @(posedge clk);
        while (!edge_in_bus.ready);
        if (mode == edt_pkg::MODE_CLEAR)
            clear_count++;
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic wait_for_results();
        @(negedge clk);
        edge_in_bus.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Random adds, mostly pairs seen before or from a narrow range, and rare clears.
    task automatic run_random_phase(input int count, input int send_pct, input int recv_pct);
        int               kind;
        edt_pkg::vertex_t va;
        edt_pkg::vertex_t vb;
        logic [31:0]      pair;
        wait_for_results();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(99);
            va = edt_pkg::vertex_t'($urandom);
            vb = edt_pkg::vertex_t'($urandom);
            if (kind < 1)
            begin
                send_edge(edt_pkg::MODE_CLEAR, va, vb, 1'b0, '0);
                recent_pairs.delete();
            end
            else
            begin
                if (kind < 36 && recent_pairs.size() != 0)
                begin
                    pair = recent_pairs[$urandom_range(recent_pairs.size() - 1)];
                    {va, vb} = $urandom_range(1) ? pair : {pair[15:0], pair[31:16]};
                end
                else if (kind < 46)
                begin
                    vb = va;
                end
                else if (kind < 71)
                begin
                    va = edt_pkg::vertex_t'($urandom_range(31));
                    vb = edt_pkg::vertex_t'($urandom_range(31));
                end
                else if (kind < 76)
                begin
                    va = $urandom_range(1) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000) : va;
                    vb = $urandom_range(1) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000) : vb;
                end
                send_edge(edt_pkg::MODE_ADD, va, vb, 1'b0, '0);
                pair = {va, vb};
                recent_pairs = {recent_pairs, pair};
                if (recent_pairs.size() > 1024)
                    void'(recent_pairs.pop_front());
            end
        end
    endtask

    initial
    begin : stimulus
        edge_in_bus.valid    = 1'b0;
        edge_in_bus.mode     = edt_pkg::MODE_ADD;
        edge_in_bus.vertex_a = '0;
        edge_in_bus.vertex_b = '0;
        edge_out_bus.ready   = 1'b0;
        pin_on               = 1'b0;
        pin_result           = '0;
        send_idle_pct        = 26;
        recv_idle_pct        = 73;
        cycle_count          = 0;
        error_count          = 0;
        accepted_items       = 0;
        clear_count          = 0;
        added_count          = 0;
        hit_count            = 0;
        full_count           = 0;
        clear_tables();
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed table: extremes, swapped and equal vertices, clears.
        for (int n = 0; n < DIRECTED_COUNT; n++)
            send_edge(DIRECTED_ROWS[n].mode, DIRECTED_ROWS[n].vertex_a,
                      DIRECTED_ROWS[n].vertex_b, DIRECTED_ROWS[n].pinned,
                      DIRECTED_ROWS[n].result);

        run_random_phase(RANDOM_PER_PHASE, 26, 73);
        run_random_phase(RANDOM_PER_PHASE, 73, 26);
        run_random_phase(RANDOM_PER_PHASE, 0, 0);

        // Drain and let the block settle before the verdict.
        wait_for_results();
        repeat (32) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end

        $display("Covered %0d transactions in %0d cycles: %0d clears, %0d edges appended,",
                 accepted_items, cycle_count, clear_count, added_count);
        $display("%0d lookups that hit, %0d refused with the table full; %0d errors.",
                 hit_count, full_count, error_count);
        if (error_count == 0)
            $display("edge_dedup_table regression: pass");
        else
            $display("edge_dedup_table regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/edt_pkg.sv
hdl/edt_if.sv
hdl/edt_ram.sv
hdl/edt_hash.sv
hdl/edge_dedup_table.sv
dv/tb_edge_dedup_table.sv
